FILE: hw/rtl/rmexu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAM machine execute unit package
// Shared types, codes and default sizes for the execute unit, its front end,
// its decoded-operation queue and its back end.
// ----------------------------------------------------------------------------
package rmexu_pkg;

   // Default sizes of the register file, the input tape and the machine word.
   localparam int REG_DEPTH_DEF  = 256;
   localparam int TAPE_DEPTH_DEF = 256;
   localparam int DATA_WIDTH_DEF = 32;

   // Queue between front and back: two entries, power of two for wrapping pointers.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [3:0] {
      OP_READ  = 4'd0,
      OP_STORE = 4'd1,
      OP_LOAD  = 4'd2,
      OP_ADD   = 4'd3,
      OP_SUB   = 4'd4,
      OP_HALF  = 4'd5,
      OP_JUMP  = 4'd6,
      OP_JPOS  = 4'd7,
      OP_JZERO = 4'd8,
      OP_JNEG  = 4'd9,
      OP_HALT  = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      MODE_DIRECT    = 2'd0,
      MODE_INDIRECT  = 2'd1,
      MODE_IMMEDIATE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_ADDRESS = 2'd1,
      ERR_TAPE    = 2'd2,
      ERR_MODE    = 2'd3
   } err_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_EXEC = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_DISPATCH,
      ST_POINTER,
      ST_OPERAND,
      ST_TAPE
   } state_type;

   // Input transaction.
   typedef struct packed {
      logic               kind;
      logic [3:0]         opcode;
      logic [1:0]         mode;
      logic signed [31:0] operand;
      logic [7:0]         tape_index;
      logic signed [31:0] tape_value;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [15:0]        next_pc;
      logic signed [31:0] accumulator;
      logic               halted;
      logic [1:0]         error;
   } rsp_type;

   // Decoded operation handed from the front to the back.
   typedef struct packed {
      logic               is_load;
      op_type             op;
      logic               indirect;
      logic               immediate;
      err_type            err;
      logic               target_ok;
      logic signed [31:0] operand;
      logic [7:0]         tape_index;
      logic signed [31:0] tape_value;
   } uop_type;

endpackage

FILE: hw/rtl/rmexu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAM machine execute unit front end
// Accepts transactions, decodes them and flags every error that does not
// depend on machine state, then hands the decoded operation to the queue.
// ----------------------------------------------------------------------------
module rmexu_front #(
   parameter int REG_DEPTH  = rmexu_pkg::REG_DEPTH_DEF,
   parameter int TAPE_DEPTH = rmexu_pkg::TAPE_DEPTH_DEF
) (
   input  logic               req_valid,
   output logic               req_ready,
   input  rmexu_pkg::req_type req_data,
   input  logic               clearing,
   output logic               q_valid,
   input  logic               q_ready,
   output rmexu_pkg::uop_type q_data
);

   logic              reg_ok;
   logic              target_ok;
   logic              tape_ok;
   rmexu_pkg::err_type err;

   // No transaction is taken while the register file is being cleared.
   assign req_ready = q_ready && !clearing;
   assign q_valid   = req_valid && !clearing;

   // Address range checks on the operand and the tape index.
   assign reg_ok    = !req_data.operand[31] &&
                      ($unsigned(req_data.operand) < 32'(REG_DEPTH));
   assign target_ok = !req_data.operand[31] && (req_data.operand[30:16] == 15'd0) &&
                      (req_data.operand[15:0] != 16'd0);
   assign tape_ok   = 32'(req_data.tape_index) < 32'(TAPE_DEPTH);

   // Errors that follow from the instruction alone, in order of precedence.
   always_comb begin
      err = rmexu_pkg::ERR_NONE;
      if (req_data.kind == rmexu_pkg::KIND_LOAD) begin
         if (!tape_ok) begin
            err = rmexu_pkg::ERR_TAPE;
         end
      end else if (req_data.opcode > rmexu_pkg::OP_HALT) begin
         err = rmexu_pkg::ERR_MODE;
      end else if (req_data.opcode <= rmexu_pkg::OP_SUB) begin
         if ((req_data.mode > rmexu_pkg::MODE_IMMEDIATE) ||
             ((req_data.opcode <= rmexu_pkg::OP_STORE) &&
              (req_data.mode == rmexu_pkg::MODE_IMMEDIATE))) begin
            err = rmexu_pkg::ERR_MODE;
         end else if ((req_data.mode != rmexu_pkg::MODE_IMMEDIATE) && !reg_ok) begin
            err = rmexu_pkg::ERR_ADDRESS;
         end
      end
   end

   // Decoded operation.
   always_comb begin
      q_data.is_load    = (req_data.kind == rmexu_pkg::KIND_LOAD);
      q_data.op         = rmexu_pkg::op_type'(req_data.opcode);
      q_data.indirect   = (req_data.mode == rmexu_pkg::MODE_INDIRECT);
      q_data.immediate  = (req_data.mode == rmexu_pkg::MODE_IMMEDIATE);
      q_data.err        = err;
      q_data.target_ok  = target_ok;
      q_data.operand    = req_data.operand;
      q_data.tape_index = req_data.tape_index;
      q_data.tape_value = req_data.tape_value;
   end

endmodule

FILE: hw/rtl/rmexu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAM machine execute unit operation queue
// A short first-in first-out queue of decoded operations that lets the front
// end and the back end stall independently of each other.
// ----------------------------------------------------------------------------
module rmexu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rmexu_pkg::uop_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rmexu_pkg::uop_type out_data
);

   rmexu_pkg::uop_type              slot_ff [rmexu_pkg::QUEUE_DEPTH];
   logic [rmexu_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [rmexu_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [rmexu_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [rmexu_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [rmexu_pkg::QCNT_W-1:0]    count_ff;
   logic [rmexu_pkg::QCNT_W-1:0]    count_in;
   logic                            push;
   logic                            pop;

   assign in_ready  = count_ff != rmexu_pkg::QCNT_W'(rmexu_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + rmexu_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + rmexu_pkg::QPTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + rmexu_pkg::QCNT_W'(1);
         2'b01:   count_in = count_ff - rmexu_pkg::QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: hw/rtl/rmexu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAM machine execute unit back end
// Holds the machine state, the register file and the input tape, carries out
// one decoded operation at a time and registers its result transaction.
// ----------------------------------------------------------------------------
module rmexu_back #(
   parameter int REG_DEPTH  = rmexu_pkg::REG_DEPTH_DEF,
   parameter int TAPE_DEPTH = rmexu_pkg::TAPE_DEPTH_DEF,
   parameter int DATA_WIDTH = rmexu_pkg::DATA_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   output logic               head_ready,
   input  rmexu_pkg::uop_type head_data,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rmexu_pkg::rsp_type rsp_data
);

   localparam int RA_W = $clog2(REG_DEPTH);
   localparam int TA_W = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
   localparam int TL_W = $clog2(TAPE_DEPTH + 1);

   // Machine state.
   rmexu_pkg::state_type  state_ff;
   rmexu_pkg::state_type  state_in;
   logic [RA_W-1:0]       clr_ff;
   logic [RA_W-1:0]       clr_in;
   logic [15:0]           pc_ff;
   logic [15:0]           pc_in;
   logic [DATA_WIDTH-1:0] acc_ff;
   logic [DATA_WIDTH-1:0] acc_in;
   logic                  halt_ff;
   logic                  halt_in;
   logic [TL_W-1:0]       tlen_ff;
   logic [TL_W-1:0]       tlen_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rmexu_pkg::rsp_type    rsp_data_ff;
   rmexu_pkg::rsp_type    rsp_data_in;

   // Register file and input tape.
   logic [DATA_WIDTH-1:0] rf_mem [REG_DEPTH];
   logic [DATA_WIDTH-1:0] rf_rdata_ff;
   logic                  rf_we;
   logic [RA_W-1:0]       rf_waddr;
   logic [DATA_WIDTH-1:0] rf_wdata;
   logic                  rf_re;
   logic [RA_W-1:0]       rf_raddr;
   logic [DATA_WIDTH-1:0] tp_mem [TAPE_DEPTH];
   logic [DATA_WIDTH-1:0] tp_rdata_ff;
   logic                  tp_we;
   logic [TA_W-1:0]       tp_waddr;
   logic [DATA_WIDTH-1:0] tp_wdata;
   logic                  tp_re;
   logic [TA_W-1:0]       tp_raddr;

   // Datapath helpers.
   logic                  out_free;
   logic                  emit;
   logic                  acc_wr;
   rmexu_pkg::err_type    err;
   logic [15:0]           npc;
   logic [63:0]           opnd64;
   logic [63:0]           tval64;
   logic [63:0]           ptr64;
   logic [63:0]           addr64;
   logic [63:0]           taddr64;
   logic [63:0]           acc64;
   logic [31:0]           ti32;
   logic                  ptr_reg_ok;
   logic                  tape_ok;
   logic                  take;
   logic [DATA_WIDTH-1:0] arith_val;
   logic [DATA_WIDTH-1:0] arith_res;

   assign clearing  = (state_ff == rmexu_pkg::ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign npc       = pc_ff + 16'd1;

   // Sign-extended views of the operand, the tape word and the pointer.
   assign opnd64 = 64'(signed'(head_data.operand));
   assign tval64 = 64'(signed'(head_data.tape_value));
   assign ptr64  = 64'(signed'(rf_rdata_ff));
   assign ti32   = 32'(head_data.tape_index);

   assign ptr_reg_ok = !ptr64[63] && (ptr64 < 64'(REG_DEPTH));

   // Tape address check: tape words are addressed from one.
   assign addr64   = (state_ff == rmexu_pkg::ST_POINTER) ? ptr64 : opnd64;
   assign tape_ok  = !addr64[63] && (addr64 != 64'd0) && (addr64 <= 64'(tlen_ff));
   assign taddr64  = addr64 - 64'd1;
   assign tp_raddr = taddr64[TA_W-1:0];

   // Jump condition on the current accumulator.
   always_comb begin
      case (head_data.op)
         rmexu_pkg::OP_JUMP:  take = 1'b1;
         rmexu_pkg::OP_JPOS:  take = !acc_ff[DATA_WIDTH-1] && (acc_ff != '0);
         rmexu_pkg::OP_JZERO: take = (acc_ff == '0);
         rmexu_pkg::OP_JNEG:  take = acc_ff[DATA_WIDTH-1];
         default:             take = 1'b0;
      endcase
   end

   // Accumulator arithmetic: the value comes from the register file or the operand.
   assign arith_val = (state_ff == rmexu_pkg::ST_OPERAND) ? rf_rdata_ff
                                                           : opnd64[DATA_WIDTH-1:0];
   always_comb begin
      case (head_data.op)
         rmexu_pkg::OP_ADD: arith_res = acc_ff + arith_val;
         rmexu_pkg::OP_SUB: arith_res = acc_ff - arith_val;
         default:           arith_res = arith_val;
      endcase
   end

   // Sequencer: next state, memory accesses and state updates.
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      pc_in      = pc_ff;
      acc_in     = acc_ff;
      halt_in    = halt_ff;
      tlen_in    = tlen_ff;
      rf_we      = 1'b0;
      rf_waddr   = '0;
      rf_wdata   = '0;
      rf_re      = 1'b0;
      rf_raddr   = opnd64[RA_W-1:0];
      tp_we      = 1'b0;
      tp_waddr   = ti32[TA_W-1:0];
      tp_wdata   = tval64[DATA_WIDTH-1:0];
      tp_re      = 1'b0;
      head_ready = 1'b0;
      emit       = 1'b0;
      acc_wr     = 1'b0;
      err        = rmexu_pkg::ERR_NONE;

      case (state_ff)
         rmexu_pkg::ST_CLEAR: begin
            rf_we    = 1'b1;
            rf_waddr = clr_ff;
            clr_in   = clr_ff + RA_W'(1);
            if (clr_ff == RA_W'(REG_DEPTH - 1)) begin
               state_in = rmexu_pkg::ST_DISPATCH;
            end
         end

         rmexu_pkg::ST_DISPATCH: begin
            if (head_valid && out_free) begin
               if (head_data.is_load) begin
                  head_ready = 1'b1;
                  emit       = 1'b1;
                  err        = head_data.err;
                  if (head_data.err == rmexu_pkg::ERR_NONE) begin
                     tp_we = 1'b1;
                     if ((ti32 + 32'd1) > 32'(tlen_ff)) begin
                        tlen_in = TL_W'(ti32 + 32'd1);
                     end
                  end
               end else if (halt_ff) begin
                  head_ready = 1'b1;
                  emit       = 1'b1;
               end else if (head_data.err != rmexu_pkg::ERR_NONE) begin
                  head_ready = 1'b1;
                  emit       = 1'b1;
                  err        = head_data.err;
               end else begin
                  case (head_data.op)
                     rmexu_pkg::OP_READ: begin
                        if (head_data.indirect) begin
                           rf_re    = 1'b1;
                           state_in = rmexu_pkg::ST_POINTER;
                        end else if (!tape_ok) begin
                           head_ready = 1'b1;
                           emit       = 1'b1;
                           err        = rmexu_pkg::ERR_TAPE;
                        end else begin
                           tp_re    = 1'b1;
                           state_in = rmexu_pkg::ST_TAPE;
                        end
                     end
                     rmexu_pkg::OP_STORE: begin
                        if (head_data.indirect) begin
                           rf_re    = 1'b1;
                           state_in = rmexu_pkg::ST_POINTER;
                        end else begin
                           rf_we      = 1'b1;
                           rf_waddr   = opnd64[RA_W-1:0];
                           rf_wdata   = acc_ff;
                           pc_in      = npc;
                           head_ready = 1'b1;
                           emit       = 1'b1;
                        end
                     end
                     rmexu_pkg::OP_LOAD, rmexu_pkg::OP_ADD, rmexu_pkg::OP_SUB: begin
                        if (head_data.immediate) begin
                           acc_in     = arith_res;
                           acc_wr     = 1'b1;
                           pc_in      = npc;
                           head_ready = 1'b1;
                           emit       = 1'b1;
                        end else begin
                           rf_re    = 1'b1;
                           state_in = head_data.indirect ? rmexu_pkg::ST_POINTER
                                                         : rmexu_pkg::ST_OPERAND;
                        end
                     end
                     rmexu_pkg::OP_HALF: begin
                        acc_in     = {acc_ff[DATA_WIDTH-1], acc_ff[DATA_WIDTH-1:1]};
                        acc_wr     = 1'b1;
                        pc_in      = npc;
                        head_ready = 1'b1;
                        emit       = 1'b1;
                     end
                     rmexu_pkg::OP_JUMP, rmexu_pkg::OP_JPOS,
                     rmexu_pkg::OP_JZERO, rmexu_pkg::OP_JNEG: begin
                        head_ready = 1'b1;
                        emit       = 1'b1;
                        if (!take) begin
                           pc_in = npc;
                        end else if (!head_data.target_ok) begin
                           err = rmexu_pkg::ERR_ADDRESS;
                        end else begin
                           pc_in = head_data.operand[15:0];
                        end
                     end
                     rmexu_pkg::OP_HALT: begin
                        halt_in    = 1'b1;
                        pc_in      = '0;
                        head_ready = 1'b1;
                        emit       = 1'b1;
                     end
                     default: begin
                        head_ready = 1'b1;
                        emit       = 1'b1;
                        err        = rmexu_pkg::ERR_MODE;
                     end
                  endcase
               end
            end
         end

         // Pointer word is in the read register: check it and go on.
         rmexu_pkg::ST_POINTER: begin
            if (out_free) begin
               if (head_data.op == rmexu_pkg::OP_READ) begin
                  if (!tape_ok) begin
                     head_ready = 1'b1;
                     emit       = 1'b1;
                     err        = rmexu_pkg::ERR_TAPE;
                     state_in   = rmexu_pkg::ST_DISPATCH;
                  end else begin
                     tp_re    = 1'b1;
                     state_in = rmexu_pkg::ST_TAPE;
                  end
               end else if (!ptr_reg_ok) begin
                  head_ready = 1'b1;
                  emit       = 1'b1;
                  err        = rmexu_pkg::ERR_ADDRESS;
                  state_in   = rmexu_pkg::ST_DISPATCH;
               end else if (head_data.op == rmexu_pkg::OP_STORE) begin
                  rf_we      = 1'b1;
                  rf_waddr   = ptr64[RA_W-1:0];
                  rf_wdata   = acc_ff;
                  pc_in      = npc;
                  head_ready = 1'b1;
                  emit       = 1'b1;
                  state_in   = rmexu_pkg::ST_DISPATCH;
               end else begin
                  rf_re    = 1'b1;
                  rf_raddr = ptr64[RA_W-1:0];
                  state_in = rmexu_pkg::ST_OPERAND;
               end
            end
         end

         rmexu_pkg::ST_OPERAND: begin
            if (out_free) begin
               acc_in     = arith_res;
               acc_wr     = 1'b1;
               pc_in      = npc;
               head_ready = 1'b1;
               emit       = 1'b1;
               state_in   = rmexu_pkg::ST_DISPATCH;
            end
         end

         rmexu_pkg::ST_TAPE: begin
            if (out_free) begin
               acc_in     = tp_rdata_ff;
               acc_wr     = 1'b1;
               pc_in      = npc;
               head_ready = 1'b1;
               emit       = 1'b1;
               state_in   = rmexu_pkg::ST_DISPATCH;
            end
         end

         default: begin
            state_in = rmexu_pkg::ST_CLEAR;
         end
      endcase

      // Register 0 mirrors the accumulator.
      if (acc_wr) begin
         rf_we    = 1'b1;
         rf_waddr = '0;
         rf_wdata = acc_in;
      end
   end

   // Result register: loaded with the state after the step.
   assign acc64 = 64'(signed'(acc_in));
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.next_pc     = pc_in;
         rsp_data_in.accumulator = acc64[31:0];
         rsp_data_in.halted      = halt_in;
         rsp_data_in.error       = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmexu_pkg::ST_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= 16'd1;
         acc_ff       <= '0;
         halt_ff      <= 1'b0;
         tlen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         halt_ff      <= halt_in;
         tlen_ff      <= tlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Register file: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
      if (rf_re) begin
         rf_rdata_ff <= rf_mem[rf_raddr];
      end
   end

   // Input tape: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (tp_we) begin
         tp_mem[tp_waddr] <= tp_wdata;
      end
      if (tp_re) begin
         tp_rdata_ff <= tp_mem[tp_raddr];
      end
   end

`ifndef SYNTHESIS
   a_acc_mirror: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rmexu_pkg::ST_CLEAR) |-> (rf_mem[0] == acc_ff))
      else $error("accumulator and register 0 disagree");

   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> (pc_ff == 16'd0))
      else $error("halted machine with non-zero program counter");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (head_valid && head_ready) == emit)
      else $error("operation retired without exactly one result");

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmexu_pkg::ST_CLEAR) |-> (!head_ready && !rsp_valid_ff))
      else $error("operation taken during the register file clear");

   a_tape_len: assert property (@(posedge clock) disable iff (reset)
      (32'(tlen_ff) <= 32'(TAPE_DEPTH)))
      else $error("tape length beyond tape depth");
`endif

endmodule

FILE: hw/rtl/ram_machine_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAM machine execute unit
// Tape loads, HALF, jumps, HALT, direct STORE and immediate operands complete in
// dispatch; direct operand and tape reads go on to the operand or tape state,
// indirect STORE to the pointer state, and indirect operand and tape reads to the
// pointer state and then the operand or tape state. Throughput is one transaction
// a cycle for the first group while results drain; others hold the back end.
// After reset the register file is cleared, req_ready low.
// ----------------------------------------------------------------------------
module ram_machine_execute_unit #(
   parameter int REG_DEPTH  = rmexu_pkg::REG_DEPTH_DEF,
   parameter int TAPE_DEPTH = rmexu_pkg::TAPE_DEPTH_DEF,
   parameter int DATA_WIDTH = rmexu_pkg::DATA_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rmexu_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rmexu_pkg::rsp_type rsp_data
);

   logic               clearing;
   logic               fq_valid;
   logic               fq_ready;
   rmexu_pkg::uop_type fq_data;
   logic               head_valid;
   logic               head_ready;
   rmexu_pkg::uop_type head_data;

   // Decode of incoming transactions.
   rmexu_front #(
      .REG_DEPTH  (REG_DEPTH),
      .TAPE_DEPTH (TAPE_DEPTH)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .clearing  (clearing),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_data    (fq_data)
   );

   // Queue of decoded operations.
   rmexu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (head_valid),
      .out_ready (head_ready),
      .out_data  (head_data)
   );

   // Execution against the machine state.
   rmexu_back #(
      .REG_DEPTH  (REG_DEPTH),
      .TAPE_DEPTH (TAPE_DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .head_data  (head_data),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: bench/ram_machine_execute_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAM machine execute unit checker
// Watches the request and result channels of the execute unit. It keeps its
// own copy of the machine state and works out each result as requests are
// accepted. Each accepted result is then compared field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ram_machine_execute_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  rmexu_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  rmexu_pkg::rsp_type rsp_data,
   output int                 mismatches,
   output int                 outstanding
);

   localparam int REG_DEPTH  = rmexu_pkg::REG_DEPTH_DEF;
   localparam int TAPE_DEPTH = rmexu_pkg::TAPE_DEPTH_DEF;

   // Shadow copy of the machine.
   logic [15:0] pc;
   logic [31:0] regs [REG_DEPTH];
   logic [31:0] tape [TAPE_DEPTH];
   int          tape_len;
   logic        halted;

   rmexu_pkg::rsp_type predicted_results [$];
   rmexu_pkg::rsp_type oldest;

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
      end
   endtask

   function automatic bit reg_ok(input longint a);
      return a >= 0 && a < REG_DEPTH;
   endfunction

   task automatic clear_machine();
      foreach (regs[i]) regs[i] = '0;
      foreach (tape[i]) tape[i] = '0;
      pc       = 16'd1;
      tape_len = 0;
      halted   = 1'b0;
      predicted_results.delete();
   endtask

   // Applies one request transaction to the shadow machine and returns the
   // result transaction it must produce.
   function automatic rmexu_pkg::rsp_type machine_step(input rmexu_pkg::req_type t);
      rmexu_pkg::rsp_type r;
      rmexu_pkg::err_type err;
      longint             opnd;
      longint             addr;
      logic [31:0]        acc;
      logic [31:0]        val;
      logic [15:0]        npc;
      logic               take;
      opnd = $signed(t.operand);
      addr = opnd;
      acc  = regs[0];
      val  = '0;
      npc  = pc + 16'd1;
      take = 1'b0;
      err  = rmexu_pkg::ERR_NONE;

      if (t.kind == rmexu_pkg::KIND_LOAD) begin
         // Every 8-bit index lies inside the tape, so loads always land.
         tape[t.tape_index] = t.tape_value;
         if (int'(t.tape_index) + 1 > tape_len) tape_len = int'(t.tape_index) + 1;
      end else if (!halted) begin
         if (t.opcode > rmexu_pkg::OP_HALT) begin
            err = rmexu_pkg::ERR_MODE;
         end else if (t.opcode <= rmexu_pkg::OP_SUB) begin
            // Operand fetch for the memory and arithmetic group.
            if (t.mode == rmexu_pkg::MODE_IMMEDIATE && t.opcode <= rmexu_pkg::OP_STORE) begin
               err = rmexu_pkg::ERR_MODE;
            end else begin
               case (t.mode)
                  rmexu_pkg::MODE_IMMEDIATE: begin
                     val = t.operand;
                  end
                  rmexu_pkg::MODE_DIRECT, rmexu_pkg::MODE_INDIRECT: begin
                     if (!reg_ok(opnd)) begin
                        err = rmexu_pkg::ERR_ADDRESS;
                     end else begin
                        // READ uses the pointer as a tape address, unchecked here.
                        if (t.mode == rmexu_pkg::MODE_INDIRECT) begin
                           addr = $signed(regs[opnd]);
                           if (t.opcode != rmexu_pkg::OP_READ && !reg_ok(addr)) begin
                              err = rmexu_pkg::ERR_ADDRESS;
                           end
                        end
                        if (err == rmexu_pkg::ERR_NONE && t.opcode >= rmexu_pkg::OP_LOAD) begin
                           val = regs[addr];
                        end
                     end
                  end
                  default: begin
                     err = rmexu_pkg::ERR_MODE;
                  end
               endcase
            end
            if (err == rmexu_pkg::ERR_NONE) begin
               case (t.opcode)
                  rmexu_pkg::OP_READ: begin
                     if (addr < 1 || addr > tape_len) err = rmexu_pkg::ERR_TAPE;
                     else regs[0] = tape[addr - 1];
                  end
                  rmexu_pkg::OP_STORE: regs[addr] = acc;
                  rmexu_pkg::OP_LOAD:  regs[0] = val;
                  rmexu_pkg::OP_ADD:   regs[0] = acc + val;
                  default:             regs[0] = acc - val;
               endcase
            end
         end else begin
            // Shift, jumps and halt ignore the addressing mode.
            case (t.opcode)
               rmexu_pkg::OP_HALF:  regs[0] = $signed(acc) >>> 1;
               rmexu_pkg::OP_JUMP:  take = 1'b1;
               rmexu_pkg::OP_JPOS:  take = $signed(acc) > 0;
               rmexu_pkg::OP_JZERO: take = acc == '0;
               rmexu_pkg::OP_JNEG:  take = $signed(acc) < 0;
               default: begin
                  halted = 1'b1;
                  npc    = '0;
               end
            endcase
            if (take) begin
               if (opnd < 1 || opnd > 65535) err = rmexu_pkg::ERR_ADDRESS;
               else npc = opnd[15:0];
            end
         end
         // A failing instruction leaves the counter where it was.
         if (err == rmexu_pkg::ERR_NONE) pc = npc;
      end

      r.next_pc     = pc;
      r.accumulator = regs[0];
      r.halted      = halted;
      r.error       = err;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_machine();
         mismatches = 0;
      end else begin
         // Compare a completed result transaction with the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               report_mismatch("result transaction with no prediction waiting");
            end else begin
               oldest = predicted_results.pop_front();
               check_field("next_pc", 32'(rsp_data.next_pc), 32'(oldest.next_pc));
               check_field("accumulator", rsp_data.accumulator, oldest.accumulator);
               check_field("halted", 32'(rsp_data.halted), 32'(oldest.halted));
               check_field("error", 32'(rsp_data.error), 32'(oldest.error));
            end
         end
         // Predict the result of a newly accepted request transaction.
         if (req_valid && req_ready) begin
            predicted_results.push_back(machine_step(req_data));
         end
      end
      outstanding = predicted_results.size();
   end

endmodule

FILE: bench/ram_machine_execute_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RAM machine execute unit testbench
// Drives a directed program through the execute unit, then a long random
// instruction stream mixed with tape loads, and finally a halt. Both channels
// idle and stall at random; the checker beside the unit predicts every result.
// ----------------------------------------------------------------------------
module ram_machine_execute_unit_tb;

   localparam int         TAPE_DEPTH    = rmexu_pkg::TAPE_DEPTH_DEF;
   localparam int         REQ_W         = $bits(rmexu_pkg::req_type);
   localparam int         RANDOM_ITEMS  = 1200;
   localparam int         DRAIN_CYCLES  = 16;
   localparam int         CYCLE_LIMIT   = 200000;
   localparam logic [1:0] MODE_RESERVED = 2'd3;
   localparam logic [3:0] OP_RESERVED   = 4'd15;

   typedef enum int {
      RX_ALWAYS,
      RX_COIN,
      RX_SPARSE,
      RX_PERIODIC
   } rx_pattern_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   rmexu_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rmexu_pkg::rsp_type rsp_data;
   int                 mismatches;
   int                 outstanding;

   int      cycles = 0;
   int      burst_left = 0;
   // Tape words 0 to tape_fill-1 have all been written.
   int      tape_fill = 0;

   ram_machine_execute_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ram_machine_execute_unit_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop for a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("ram_machine_execute_unit test failed");
         $finish;
      end
   end

   // Result side: each stretch follows one stall pattern.
   initial begin
      rx_pattern_type pattern;
      int             span;
      rsp_ready = 1'b0;
      forever begin
         pattern = rx_pattern_type'($urandom_range(0, 3));
         span    = $urandom_range(8, 64);
         for (int i = 0; i < span; i++) begin
            @(negedge clock);
            case (pattern)
               RX_ALWAYS:   rsp_ready <= 1'b1;
               RX_COIN:     rsp_ready <= $urandom_range(0, 1) == 1;
               RX_SPARSE:   rsp_ready <= $urandom_range(0, 3) == 0;
               default:     rsp_ready <= (i % 3) != 0;
            endcase
         end
      end
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3, 4:    return $urandom_range(0, 20);
         5, 6:    return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // Mostly a small working set of registers, sometimes any, rarely a bad one.
   function automatic logic [31:0] pick_register();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 15);
      if (roll < 94) return $urandom_range(0, 255);
      case ($urandom_range(0, 3))
         0:       return 32'h8000_0000;
         1:       return 32'd256;
         2:       return $urandom | 32'h8000_0000;
         default: return $urandom_range(257, 65535);
      endcase
   endfunction

   function automatic logic [31:0] pick_target();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 65535);
      if (roll < 90) return 32'd65535;
      case ($urandom_range(0, 2))
         0:       return 32'd0;
         1:       return 32'd65536;
         default: return $urandom | 32'h8000_0000;
      endcase
   endfunction

   // Fields an item does not use still carry random bits.
   function automatic rmexu_pkg::req_type exec_item(input logic [3:0] op,
                                                    input logic [1:0] mode,
                                                    input logic [31:0] operand);
      rmexu_pkg::req_type t;
      t         = rmexu_pkg::req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      t.kind    = rmexu_pkg::KIND_EXEC;
      t.opcode  = op;
      t.mode    = mode;
      t.operand = operand;
      return t;
   endfunction

   // Callers keep the index at or below tape_fill so that the tape stays
   // written without holes.
   function automatic rmexu_pkg::req_type load_item(input logic [7:0] index,
                                                    input logic [31:0] value);
      rmexu_pkg::req_type t;
      t            = rmexu_pkg::req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      t.kind       = rmexu_pkg::KIND_LOAD;
      t.tape_index = index;
      t.tape_value = value;
      if (int'(index) == tape_fill) tape_fill++;
      return t;
   endfunction

   function automatic rmexu_pkg::req_type random_tape_load();
      logic [7:0] index;
      if (tape_fill < TAPE_DEPTH) begin
         index = ($urandom_range(0, 9) < 7) ? tape_fill[7:0]
                                            : 8'($urandom_range(0, tape_fill));
      end else begin
         index = 8'($urandom_range(0, TAPE_DEPTH - 1));
      end
      return load_item(index, random_word());
   endfunction

   // Random instruction, never HALT, mostly well formed.
   function automatic rmexu_pkg::req_type random_instruction();
      logic [3:0]  op;
      logic [1:0]  mode;
      logic [31:0] operand;
      int          roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)      op = rmexu_pkg::OP_READ;
      else if (roll < 25) op = rmexu_pkg::OP_STORE;
      else if (roll < 40) op = rmexu_pkg::OP_LOAD;
      else if (roll < 52) op = rmexu_pkg::OP_ADD;
      else if (roll < 64) op = rmexu_pkg::OP_SUB;
      else if (roll < 71) op = rmexu_pkg::OP_HALF;
      else if (roll < 78) op = rmexu_pkg::OP_JUMP;
      else if (roll < 84) op = rmexu_pkg::OP_JPOS;
      else if (roll < 91) op = rmexu_pkg::OP_JZERO;
      else if (roll < 97) op = rmexu_pkg::OP_JNEG;
      else op = 4'($urandom_range(int'(rmexu_pkg::OP_HALT) + 1, int'(OP_RESERVED)));

      roll = $urandom_range(0, 99);
      if (op == rmexu_pkg::OP_READ || op == rmexu_pkg::OP_STORE) begin
         if (roll < 70)      mode = rmexu_pkg::MODE_DIRECT;
         else if (roll < 95) mode = rmexu_pkg::MODE_INDIRECT;
         else if (roll < 98) mode = rmexu_pkg::MODE_IMMEDIATE;
         else                mode = MODE_RESERVED;
      end else if (op <= rmexu_pkg::OP_SUB) begin
         if (roll < 45)      mode = rmexu_pkg::MODE_DIRECT;
         else if (roll < 65) mode = rmexu_pkg::MODE_INDIRECT;
         else if (roll < 96) mode = rmexu_pkg::MODE_IMMEDIATE;
         else                mode = MODE_RESERVED;
      end else begin
         mode = 2'($urandom_range(0, 3));
      end

      if (op >= rmexu_pkg::OP_JUMP && op <= rmexu_pkg::OP_JNEG) begin
         operand = pick_target();
      end else if (op <= rmexu_pkg::OP_SUB && mode == rmexu_pkg::MODE_IMMEDIATE) begin
         operand = random_word();
      end else if (op <= rmexu_pkg::OP_SUB) begin
         operand = pick_register();
      end else begin
         operand = $urandom;
      end
      return exec_item(op, mode, operand);
   endfunction

   // Presents one request transaction, with a random gap between bursts.
   task automatic send_transaction(input rmexu_pkg::req_type t);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed program: tape edges, wrapping arithmetic, shifts, jumps,
      // indirect access and each kind of error.
      send_transaction(exec_item(rmexu_pkg::OP_READ, rmexu_pkg::MODE_DIRECT, 32'd1)); // empty
      send_transaction(load_item(8'd0, 32'h8000_0000));
      send_transaction(load_item(8'd1, 32'h7FFF_FFFF));
      send_transaction(exec_item(rmexu_pkg::OP_READ, rmexu_pkg::MODE_DIRECT, 32'd2));
      send_transaction(exec_item(rmexu_pkg::OP_STORE, rmexu_pkg::MODE_DIRECT, 32'd255));
      send_transaction(exec_item(rmexu_pkg::OP_READ, rmexu_pkg::MODE_DIRECT, 32'd1));
      // Sums to -1.
      send_transaction(exec_item(rmexu_pkg::OP_ADD, rmexu_pkg::MODE_DIRECT, 32'd255));
      send_transaction(exec_item(rmexu_pkg::OP_SUB, rmexu_pkg::MODE_IMMEDIATE, 32'h7FFF_FFFF));
      // Wraps to the largest positive word.
      send_transaction(exec_item(rmexu_pkg::OP_SUB, rmexu_pkg::MODE_IMMEDIATE, 32'd1));
      send_transaction(exec_item(rmexu_pkg::OP_HALF, rmexu_pkg::MODE_DIRECT, 32'd0));
      send_transaction(exec_item(rmexu_pkg::OP_LOAD, rmexu_pkg::MODE_IMMEDIATE, 32'hFFFF_FFFD));
      // The shift keeps the sign.
      send_transaction(exec_item(rmexu_pkg::OP_HALF, rmexu_pkg::MODE_DIRECT, 32'd0));
      // Not taken, so the bad target goes unnoticed.
      send_transaction(exec_item(rmexu_pkg::OP_JPOS, rmexu_pkg::MODE_DIRECT, 32'd0));
      send_transaction(exec_item(rmexu_pkg::OP_JNEG, rmexu_pkg::MODE_DIRECT, 32'd100));
      send_transaction(exec_item(rmexu_pkg::OP_LOAD, rmexu_pkg::MODE_IMMEDIATE, 32'd5));
      send_transaction(exec_item(rmexu_pkg::OP_STORE, rmexu_pkg::MODE_DIRECT, 32'd3));
      send_transaction(exec_item(rmexu_pkg::OP_LOAD, rmexu_pkg::MODE_IMMEDIATE, 32'd42));
      send_transaction(exec_item(rmexu_pkg::OP_STORE, rmexu_pkg::MODE_INDIRECT, 32'd3));
      send_transaction(exec_item(rmexu_pkg::OP_ADD, rmexu_pkg::MODE_INDIRECT, 32'd3));
      // Pointer out of range.
      send_transaction(exec_item(rmexu_pkg::OP_LOAD, rmexu_pkg::MODE_INDIRECT, 32'd255));
      // Tape address too high.
      send_transaction(exec_item(rmexu_pkg::OP_READ, rmexu_pkg::MODE_INDIRECT, 32'd255));
      send_transaction(exec_item(rmexu_pkg::OP_SUB, rmexu_pkg::MODE_IMMEDIATE, 32'd84));
      // Taken, with a bad target.
      send_transaction(exec_item(rmexu_pkg::OP_JZERO, rmexu_pkg::MODE_DIRECT, 32'd0));
      send_transaction(exec_item(rmexu_pkg::OP_JZERO, rmexu_pkg::MODE_DIRECT, 32'd65535));
      send_transaction(exec_item(rmexu_pkg::OP_LOAD, rmexu_pkg::MODE_DIRECT, 32'd256));
      send_transaction(exec_item(rmexu_pkg::OP_STORE, rmexu_pkg::MODE_IMMEDIATE, 32'd1));
      send_transaction(exec_item(rmexu_pkg::OP_LOAD, MODE_RESERVED, 32'd1));
      send_transaction(exec_item(OP_RESERVED, rmexu_pkg::MODE_DIRECT, 32'd1));
      // The counter wraps to 0.
      send_transaction(exec_item(rmexu_pkg::OP_LOAD, rmexu_pkg::MODE_IMMEDIATE, 32'd1));

      // Random stream of instructions and tape loads.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 25) send_transaction(random_tape_load());
         else send_transaction(random_instruction());
      end

      // Halt, then show that instructions are ignored while loads still land.
      send_transaction(exec_item(rmexu_pkg::OP_HALT, 2'($urandom_range(0, 3)), $urandom));
      send_transaction(exec_item(rmexu_pkg::OP_LOAD, rmexu_pkg::MODE_IMMEDIATE, 32'd7));
      send_transaction(exec_item(OP_RESERVED, MODE_RESERVED, $urandom));
      send_transaction(random_tape_load());
      send_transaction(exec_item(rmexu_pkg::OP_HALT, rmexu_pkg::MODE_DIRECT, 32'd0));

      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("ram_machine_execute_unit test passed");
      end else begin
         $display("ram_machine_execute_unit test failed");
      end
      $finish;
   end

endmodule
